FILE: rtl/frequency_to_note_cents_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the frequency to note/cents core
// Clocked implication checks on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef FREQUENCY_TO_NOTE_CENTS_CORE_ASSERT_SVH
`define FREQUENCY_TO_NOTE_CENTS_CORE_ASSERT_SVH

// same-cycle implication
`define FNTC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fntc: same-cycle check failed");

// next-cycle implication
`define FNTC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fntc: next-cycle check failed");

`endif

FILE: rtl/fntc_pkg.sv
// ---------------------------------------------------------------------------
// fntc_pkg
// Shared constants and the lane type that flows through the log2 cell row.
// ---------------------------------------------------------------------------
package fntc_pkg;

    localparam int LOG_FRAC_BITS  = 16;   // fraction bits of log2
    localparam int FREQ_FRAC_BITS = 8;    // fraction bits of the input frequency
    localparam int REF_FRAC_BITS  = 8;    // fraction bits of the A4 register

    localparam int FREQ_W = 24;
    localparam int REF_W  = 17;
    localparam int MANT_W = 32;           // normalized mantissa, 1.31
    localparam int MSB_W  = 5;            // leading-one position

    localparam logic [REF_W-1:0] REF_RESET = 17'd112640;   // 440 Hz

    localparam int A4_SEMITONE = 57;
    localparam int SEMIS       = 12;
    localparam int CENTS_SCALE = 1000;    // tenths of a cent per semitone
    localparam int OCT_BIAS    = 32;      // keeps the octave divide non-negative
    localparam int RECIP12     = 2731;    // ceil(2^15 / 12)
    localparam int RECIP_SHIFT = 15;

    localparam int FRONT_STAGES = 2;
    localparam int BACK_STAGES  = 6;
    localparam int PIPE_LAT     = FRONT_STAGES + LOG_FRAC_BITS + BACK_STAGES;

    typedef struct packed {
        logic                     live;     // a word occupies this stage
        logic                     ok;       // frequency and reference nonzero
        logic [MSB_W-1:0]         msb_f;
        logic [MSB_W-1:0]         msb_r;
        logic [MANT_W-1:0]        mant_f;
        logic [MANT_W-1:0]        mant_r;
        logic [LOG_FRAC_BITS-1:0] frac_f;
        logic [LOG_FRAC_BITS-1:0] frac_r;
    } fntc_lane_t;

endpackage

FILE: rtl/frequency_to_note_cents_core.sv
// ---------------------------------------------------------------------------
// frequency_to_note_cents_core
// Frequency (Q16.8 Hz) to equal-temperament note class, octave and cents.
// ---------------------------------------------------------------------------
// Channel   | Signals                                   | Direction | Handshake
// ----------+-------------------------------------------+-----------+---------------
// input     | start, busy, freq_q8                      | in        | start & !busy
// result    | done, valid_res, note_class,              | out       | done, 1 cycle
//           | octave_number, cents_tenths               |           |
// config    | cfg_we, cfg_data (A4 reference, Hz*256)   | in        | cfg_we
//
// One word enters per cycle; busy is always low.
// done rises once the word has passed the leading-one detect and normalize
// registers, 16 squaring cells (one per log2 fraction bit), then the index,
// rounding, cents and octave arithmetic registers; the result fields are
// presented together with done.
// rst_n clears all pipeline valid flags and sets the A4 reference to 440 Hz.
// The receiver cannot stall; done is a single-cycle strobe per word.
// ---------------------------------------------------------------------------
module frequency_to_note_cents_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [fntc_pkg::FREQ_W-1:0] freq_q8,
    input  logic                        cfg_we,
    input  logic [fntc_pkg::REF_W-1:0]  cfg_data,
    output logic                        done,
    output logic                        valid_res,
    output logic [3:0]                  note_class,
    output logic signed [4:0]           octave_number,
    output logic signed [9:0]           cents_tenths
);
    import fntc_pkg::*;

    // A4 reference register
    logic [REF_W-1:0] a4_ref_reg, a4_ref_next;

    // lane handed from cell to cell; entry 0 is the normalizer output
    fntc_lane_t chain [0:LOG_FRAC_BITS];

    assign a4_ref_next = cfg_we ? cfg_data : a4_ref_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a4_ref_reg <= REF_RESET;
        else
            a4_ref_reg <= a4_ref_next;
    end

    // fully pipelined: never refuses a word
    assign busy = 1'b0;

    fntc_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .freq_q8  (freq_q8),
        .ref_q8   (a4_ref_reg),
        .lane_out (chain[0])
    );

    // each cell produces one log2 fraction bit for both operands
    for (genvar g = 0; g < LOG_FRAC_BITS; g++)
    begin : g_cell
        fntc_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .lane_in  (chain[g]),
            .lane_out (chain[g+1])
        );
    end

    fntc_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .lane_in       (chain[LOG_FRAC_BITS]),
        .done          (done),
        .valid_res     (valid_res),
        .note_class    (note_class),
        .octave_number (octave_number),
        .cents_tenths  (cents_tenths)
    );

endmodule

FILE: rtl/fntc_front.sv
// ---------------------------------------------------------------------------
// fntc_front
// Leading-one detect and mantissa normalization for frequency and reference.
// ---------------------------------------------------------------------------
module fntc_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [fntc_pkg::FREQ_W-1:0] freq_q8,
    input  logic [fntc_pkg::REF_W-1:0]  ref_q8,
    output fntc_pkg::fntc_lane_t        lane_out
);
    import fntc_pkg::*;

    logic              live1_reg, live1_next;
    logic              ok1_reg, ok1_next;
    logic [FREQ_W-1:0] f1_reg;
    logic [REF_W-1:0]  r1_reg;
    logic [MSB_W-1:0]  msb_f1_reg, msb_f1_next;
    logic [MSB_W-1:0]  msb_r1_reg, msb_r1_next;
    fntc_lane_t        lane_reg, lane_next;

    // stage 1: leading-one positions
    always_comb
    begin
        msb_f1_next = '0;
        msb_r1_next = '0;
        for (int i = 0; i < FREQ_W; i++)
        begin
            if (freq_q8[i])
                msb_f1_next = MSB_W'(i);
        end
        for (int j = 0; j < REF_W; j++)
        begin
            if (ref_q8[j])
                msb_r1_next = MSB_W'(j);
        end
        live1_next = start;
        ok1_next   = (freq_q8 != '0) && (ref_q8 != '0);
    end

    // stage 2: shift leading one up to bit 31
    always_comb
    begin
        lane_next        = '0;
        lane_next.live   = live1_reg;
        lane_next.ok     = ok1_reg;
        lane_next.msb_f  = msb_f1_reg;
        lane_next.msb_r  = msb_r1_reg;
        lane_next.mant_f = MANT_W'(f1_reg) << (MSB_W'(MANT_W - 1) - msb_f1_reg);
        lane_next.mant_r = MANT_W'(r1_reg) << (MSB_W'(MANT_W - 1) - msb_r1_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live1_reg  <= 1'b0;
            ok1_reg    <= 1'b0;
            f1_reg     <= '0;
            r1_reg     <= '0;
            msb_f1_reg <= '0;
            msb_r1_reg <= '0;
            lane_reg   <= '0;
        end
        else
        begin
            live1_reg  <= live1_next;
            ok1_reg    <= ok1_next;
            f1_reg     <= freq_q8;
            r1_reg     <= ref_q8;
            msb_f1_reg <= msb_f1_next;
            msb_r1_reg <= msb_r1_next;
            lane_reg   <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

FILE: rtl/fntc_cell.sv
// ---------------------------------------------------------------------------
// fntc_cell
// One log2 fraction bit: squares both mantissas and shifts the bit in.
// ---------------------------------------------------------------------------
module fntc_cell
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  fntc_pkg::fntc_lane_t lane_in,
    output fntc_pkg::fntc_lane_t lane_out
);
    import fntc_pkg::*;

    logic [2*MANT_W-1:0] sq_f, sq_r;
    logic [MANT_W:0]     sh_f, sh_r;
    logic                bit_f, bit_r;
    fntc_lane_t          lane_reg, lane_next;

    always_comb
    begin
        sq_f  = (2*MANT_W)'(lane_in.mant_f) * (2*MANT_W)'(lane_in.mant_f);
        sq_r  = (2*MANT_W)'(lane_in.mant_r) * (2*MANT_W)'(lane_in.mant_r);
        sh_f  = sq_f[2*MANT_W-1:MANT_W-1];
        sh_r  = sq_r[2*MANT_W-1:MANT_W-1];
        bit_f = sh_f[MANT_W];
        bit_r = sh_r[MANT_W];

        lane_next        = lane_in;
        lane_next.mant_f = bit_f ? sh_f[MANT_W:1] : sh_f[MANT_W-1:0];
        lane_next.mant_r = bit_r ? sh_r[MANT_W:1] : sh_r[MANT_W-1:0];
        lane_next.frac_f = {lane_in.frac_f[LOG_FRAC_BITS-2:0], bit_f};
        lane_next.frac_r = {lane_in.frac_r[LOG_FRAC_BITS-2:0], bit_r};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lane_reg <= '0;
        else
            lane_reg <= lane_next;
    end

    assign lane_out = lane_reg;

endmodule

FILE: rtl/fntc_back.sv
// ---------------------------------------------------------------------------
// fntc_back
// Semitone index, rounding, cents scaling and floored octave split.
// ---------------------------------------------------------------------------
module fntc_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  fntc_pkg::fntc_lane_t lane_in,
    output logic                 done,
    output logic                 valid_res,
    output logic [3:0]           note_class,
    output logic signed [4:0]    octave_number,
    output logic signed [9:0]    cents_tenths
);
    import fntc_pkg::*;

    localparam int L_W  = MSB_W + 2 + LOG_FRAC_BITS;
    localparam int I_W  = L_W + 5;
    localparam int N_W  = I_W - LOG_FRAC_BITS;
    localparam int P_W  = LOG_FRAC_BITS + 10;
    localparam int T_W  = P_W - LOG_FRAC_BITS;
    localparam int V_W  = 10;
    localparam int Q_W  = 7;
    localparam int HALF = 1 << (LOG_FRAC_BITS - 1);
    localparam int CORR = REF_FRAC_BITS - FREQ_FRAC_BITS;

    // E1: log2 ratio
    logic                    e1_live_reg, e1_ok_reg;
    logic signed [L_W-1:0]   e1_l_reg, e1_l_next, ip_e1;
    // E2: semitone index
    logic                    e2_live_reg, e2_ok_reg;
    logic signed [I_W-1:0]   e2_idx_reg, e2_idx_next;
    // E3: rounding
    logic                    e3_live_reg, e3_ok_reg, e3_neg_reg, e3_neg_next;
    logic [I_W-1:0]          abs_e3, sum_e3;
    logic [N_W-1:0]          e3_n_reg, e3_n_next;
    logic signed [LOG_FRAC_BITS:0] e3_dm_reg, e3_dm_next;
    // E4: cents magnitude, octave bias
    logic                    e4_live_reg, e4_ok_reg, e4_dneg_reg, e4_dneg_next;
    logic [LOG_FRAC_BITS-1:0] ad_e4;
    logic [P_W-1:0]          prod_e4;
    logic signed [N_W:0]     note_e4;
    logic [T_W-1:0]          e4_t_reg, e4_t_next;
    logic [V_W-1:0]          e4_v_reg, e4_v_next;
    // E5: reciprocal divide, cents sign
    logic                    e5_live_reg, e5_ok_reg;
    logic [V_W+11:0]         qprod_e5;
    logic [Q_W-1:0]          e5_q_reg, e5_q_next;
    logic [V_W-1:0]          e5_v_reg;
    logic signed [T_W-1:0]   e5_ts_reg, e5_ts_next;
    // E6: class, octave, output
    logic [V_W-1:0]          rem_e6;
    logic signed [7:0]       oct_e6;
    logic                    good_e6;
    logic                    done_reg, valid_reg;
    logic [3:0]              class_reg;
    logic signed [4:0]       oct_reg;
    logic signed [9:0]       cents_reg;

    always_comb
    begin
        ip_e1 = L_W'($signed({1'b0, lane_in.msb_f})) - L_W'($signed({1'b0, lane_in.msb_r}))
              + L_W'(CORR);
        e1_l_next = (ip_e1 <<< LOG_FRAC_BITS)
                  + L_W'($signed({1'b0, lane_in.frac_f}))
                  - L_W'($signed({1'b0, lane_in.frac_r}));

        e2_idx_next = (I_W'(A4_SEMITONE) <<< LOG_FRAC_BITS)
                    + (I_W'(e1_l_reg) <<< 3) + (I_W'(e1_l_reg) <<< 2);

        // ties away from zero: round the magnitude
        e3_neg_next = e2_idx_reg[I_W-1];
        abs_e3      = e3_neg_next ? I_W'(-e2_idx_reg) : I_W'(e2_idx_reg);
        sum_e3      = abs_e3 + I_W'(HALF);
        e3_n_next   = sum_e3[I_W-1:LOG_FRAC_BITS];
        e3_dm_next  = $signed({1'b0, sum_e3[LOG_FRAC_BITS-1:0]})
                    - $signed((LOG_FRAC_BITS+1)'(HALF));

        e4_dneg_next = e3_neg_reg ? (e3_dm_reg > 0) : (e3_dm_reg < 0);
        ad_e4        = LOG_FRAC_BITS'(e3_dm_reg < 0 ? -e3_dm_reg : e3_dm_reg);
        prod_e4      = P_W'(ad_e4) * P_W'(CENTS_SCALE) + P_W'(HALF);
        e4_t_next    = prod_e4[P_W-1:LOG_FRAC_BITS];
        note_e4      = e3_neg_reg ? -$signed({1'b0, e3_n_reg}) : $signed({1'b0, e3_n_reg});
        e4_v_next    = V_W'(note_e4 + (N_W+1)'(OCT_BIAS * SEMIS));

        // exact floor(v/12) over the whole v range
        qprod_e5   = (V_W+12)'(e4_v_reg) * (V_W+12)'(RECIP12);
        e5_q_next  = qprod_e5[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];
        e5_ts_next = e4_dneg_reg ? -$signed(e4_t_reg) : $signed(e4_t_reg);

        rem_e6  = e5_v_reg - V_W'(e5_q_reg) * V_W'(SEMIS);
        oct_e6  = $signed(8'({1'b0, e5_q_reg})) - 8'(OCT_BIAS);
        good_e6 = e5_ok_reg && (oct_e6 >= -8'sd16) && (oct_e6 <= 8'sd15);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_live_reg <= 1'b0;
            e1_ok_reg   <= 1'b0;
            e1_l_reg    <= '0;
            e2_live_reg <= 1'b0;
            e2_ok_reg   <= 1'b0;
            e2_idx_reg  <= '0;
            e3_live_reg <= 1'b0;
            e3_ok_reg   <= 1'b0;
            e3_neg_reg  <= 1'b0;
            e3_n_reg    <= '0;
            e3_dm_reg   <= '0;
            e4_live_reg <= 1'b0;
            e4_ok_reg   <= 1'b0;
            e4_dneg_reg <= 1'b0;
            e4_t_reg    <= '0;
            e4_v_reg    <= '0;
            e5_live_reg <= 1'b0;
            e5_ok_reg   <= 1'b0;
            e5_q_reg    <= '0;
            e5_v_reg    <= '0;
            e5_ts_reg   <= '0;
            done_reg    <= 1'b0;
            valid_reg   <= 1'b0;
            class_reg   <= '0;
            oct_reg     <= '0;
            cents_reg   <= '0;
        end
        else
        begin
            e1_live_reg <= lane_in.live;
            e1_ok_reg   <= lane_in.ok;
            e1_l_reg    <= e1_l_next;
            e2_live_reg <= e1_live_reg;
            e2_ok_reg   <= e1_ok_reg;
            e2_idx_reg  <= e2_idx_next;
            e3_live_reg <= e2_live_reg;
            e3_ok_reg   <= e2_ok_reg;
            e3_neg_reg  <= e3_neg_next;
            e3_n_reg    <= e3_n_next;
            e3_dm_reg   <= e3_dm_next;
            e4_live_reg <= e3_live_reg;
            e4_ok_reg   <= e3_ok_reg;
            e4_dneg_reg <= e4_dneg_next;
            e4_t_reg    <= e4_t_next;
            e4_v_reg    <= e4_v_next;
            e5_live_reg <= e4_live_reg;
            e5_ok_reg   <= e4_ok_reg;
            e5_q_reg    <= e5_q_next;
            e5_v_reg    <= e4_v_reg;
            e5_ts_reg   <= e5_ts_next;
            done_reg    <= e5_live_reg;
            valid_reg   <= good_e6;
            class_reg   <= good_e6 ? rem_e6[3:0] : 4'd0;
            oct_reg     <= good_e6 ? oct_e6[4:0] : 5'sd0;
            cents_reg   <= good_e6 ? e5_ts_reg : 10'sd0;
        end
    end

    assign done          = done_reg;
    assign valid_res     = valid_reg;
    assign note_class    = class_reg;
    assign octave_number = oct_reg;
    assign cents_tenths  = cents_reg;

endmodule

FILE: rtl/fntc_checker.sv
// ---------------------------------------------------------------------------
// fntc_checker
// Port-level timing and range checks, bound to the top level.
// ---------------------------------------------------------------------------
`include "frequency_to_note_cents_core_assert.svh"

module fntc_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic [fntc_pkg::FREQ_W-1:0] freq_q8,
    input logic                        done,
    input logic                        valid_res,
    input logic [3:0]                  note_class,
    input logic signed [4:0]           octave_number,
    input logic signed [9:0]           cents_tenths
);
    import fntc_pkg::*;

    // every accepted word comes out after the fixed latency
    `FNTC_ASSERT_IMP(a_lat_hit, start && !busy, ##PIPE_LAT done)

    // no strobe without a word accepted at the matching edge
    `FNTC_ASSERT_IMP(a_lat_miss, !(start && !busy), ##PIPE_LAT !done)

    // a zero frequency never yields a valid note
    `FNTC_ASSERT_IMP(a_zero_freq, start && !busy && (freq_q8 == '0), ##PIPE_LAT !valid_res)

    // invalid results carry zero fields
    `FNTC_ASSERT_IMP(a_invalid_zero, done && !valid_res,
        note_class == 4'd0 && octave_number == 5'sd0 && cents_tenths == 10'sd0)

    // valid results stay in range
    `FNTC_ASSERT_IMP(a_range, done && valid_res,
        note_class <= 4'd11 && cents_tenths >= -10'sd500 && cents_tenths <= 10'sd500)

endmodule

bind frequency_to_note_cents_core fntc_checker u_fntc_checker (.*);
